/* sv/ulakb_pkg.sv */
// Shared types and constants of the keyboard, border and beeper port block.
package ulakb_pkg;

  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_FRAME = 2'd3;

  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_KEY   = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_FRAME = 3'd4;

  localparam int          KEY_ROWS       = 8;
  localparam int          KEY_COLS       = 5;
  localparam logic [4:0]  ROW_RELEASED   = 5'h1F;
  localparam logic [7:0]  READ_IDLE      = 8'hFF;
  localparam logic [7:0]  READ_FORCE_HI  = 8'hA0;
  localparam logic [2:0]  BORDER_RESET   = 3'd7;
  localparam logic [17:0] FRAME_CYC_RESET = 18'd70000;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  key_row;
    logic [4:0]  key_mask;
    logic        key_pressed;
    logic [7:0]  row_select;
    logic        ear_level;
    logic [7:0]  write_value;
    logic [17:0] cycle;
  } ulakb_req_t;

endpackage

/* sv/ulakb_front.sv */
// Front end: input handshake and classification of each request.
module ulakb_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [3:0]         in_key_row,
  input  logic [3:0]         in_key_bit,
  input  logic               in_key_pressed,
  input  logic [7:0]         in_port_addr,
  input  logic [7:0]         in_row_select,
  input  logic [7:0]         in_write_value,
  input  logic [17:0]        in_cycle,
  input  logic               in_ear_level,
  input  logic               q_full,
  output logic               q_push,
  output ulakb_pkg::ulakb_req_t q_req
);
  import ulakb_pkg::*;

  logic key_ok;
  logic even_port;

  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;
  assign key_ok    = (in_key_row < 4'(KEY_ROWS)) && (in_key_bit < 4'(KEY_COLS));
  assign even_port = !in_port_addr[0];

  always_comb begin
    q_req.op          = OP_NOP;
    q_req.key_row     = in_key_row[2:0];
    q_req.key_mask    = 5'(5'd1 << in_key_bit[2:0]);
    q_req.key_pressed = in_key_pressed;
    q_req.row_select  = in_row_select;
    q_req.ear_level   = in_ear_level;
    q_req.write_value = in_write_value;
    q_req.cycle       = in_cycle;
    case (in_kind)
      KIND_KEY:   q_req.op = key_ok ? OP_KEY : OP_NOP;
      KIND_READ:  q_req.op = even_port ? OP_READ : OP_NOP;
      KIND_WRITE: q_req.op = even_port ? OP_WRITE : OP_NOP;
      KIND_FRAME: q_req.op = OP_FRAME;
      default:    q_req.op = OP_NOP;
    endcase
  end

endmodule

/* sv/ulakb_queue.sv */
// Short request queue between front end and back end.
module ulakb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             not_empty,
  output logic             full
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign head_data = mem_r[rd_ptr_r];
  assign not_empty = count_r != '0;
  assign full      = count_r == CW'(DEPTH);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
      count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

/* sv/ulakb_back.sv */
// Back end: keyboard matrix, port state, edge logging and result register.
module ulakb_back #(
  parameter int MAX_EDGES = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [17:0]           cfg_data,
  input  logic                  q_not_empty,
  input  ulakb_pkg::ulakb_req_t q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_read_data,
  output logic [2:0]            out_border_color,
  output logic                  out_mic_out,
  output logic                  out_beeper_out,
  output logic                  out_edge_valid,
  output logic [17:0]           out_edge_cycle,
  output logic                  out_edge_level,
  output logic                  out_edge_dropped,
  output logic [15:0]           out_edge_index,
  output logic                  out_start_level
);
  import ulakb_pkg::*;

  localparam int CW = $clog2(MAX_EDGES + 1);

  logic [4:0]    keys_r [KEY_ROWS];
  logic [4:0]    keys_nxt [KEY_ROWS];
  logic [2:0]    border_r, border_nxt;
  logic          mic_r, mic_nxt;
  logic          beeper_r, beeper_nxt;
  logic          start_r, start_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [17:0]   frame_cyc_r;
  logic          out_valid_r;

  logic [7:0]    rd;
  logic [4:0]    row_and;
  logic          ev, elev, edrop;
  logic [17:0]   ecyc;
  logic [15:0]   eidx;
  logic [16:0]   count_ext;
  logic          nb;

  logic [7:0]    rd_r;
  logic [2:0]    border_o_r;
  logic          mic_o_r, beeper_o_r, ev_r, elev_r, edrop_r, start_o_r;
  logic [17:0]   ecyc_r;
  logic [15:0]   eidx_r;

  assign cfg_ready = 1'b1;
  assign q_pop     = q_not_empty && (!out_valid_r || !out_stall);
  assign count_ext = 17'(count_r);
  assign nb        = q_head.write_value[4];

  always_comb begin
    row_and = ROW_RELEASED;
    for (int i = 0; i < KEY_ROWS; i++) begin
      if (!q_head.row_select[i]) begin
        row_and = row_and & keys_r[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < KEY_ROWS; i++) begin
      keys_nxt[i] = keys_r[i];
    end
    border_nxt = border_r;
    mic_nxt    = mic_r;
    beeper_nxt = beeper_r;
    start_nxt  = start_r;
    count_nxt  = count_r;
    rd         = READ_IDLE;
    ev         = 1'b0;
    elev       = 1'b0;
    edrop      = 1'b0;
    ecyc       = '0;
    eidx       = '0;
    case (q_head.op)
      OP_KEY: begin
        if (q_head.key_pressed) begin
          keys_nxt[q_head.key_row] = keys_r[q_head.key_row] & ~q_head.key_mask;
        end else begin
          keys_nxt[q_head.key_row] = keys_r[q_head.key_row] | q_head.key_mask;
        end
      end
      OP_READ: begin
        rd = {2'b11, 1'b1, row_and} | READ_FORCE_HI;
        rd[6] = q_head.ear_level;
      end
      OP_WRITE: begin
        border_nxt = q_head.write_value[2:0];
        mic_nxt    = q_head.write_value[3];
        if (nb != beeper_r) begin
          beeper_nxt = nb;
          if (count_r >= CW'(MAX_EDGES)) begin
            edrop = 1'b1;
          end else begin
            ev        = 1'b1;
            elev      = nb;
            ecyc      = (q_head.cycle > frame_cyc_r) ? frame_cyc_r : q_head.cycle;
            eidx      = count_ext[15:0];
            count_nxt = count_r + CW'(1);
          end
        end
      end
      OP_FRAME: begin
        start_nxt = beeper_r;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_ROWS; i++) begin
        keys_r[i] <= ROW_RELEASED;
      end
      border_r    <= BORDER_RESET;
      mic_r       <= 1'b0;
      beeper_r    <= 1'b0;
      start_r     <= 1'b0;
      count_r     <= '0;
      frame_cyc_r <= FRAME_CYC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        frame_cyc_r <= cfg_data;
      end
      if (q_pop) begin
        for (int i = 0; i < KEY_ROWS; i++) begin
          keys_r[i] <= keys_nxt[i];
        end
        border_r <= border_nxt;
        mic_r    <= mic_nxt;
        beeper_r <= beeper_nxt;
        start_r  <= start_nxt;
        count_r  <= count_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_r       <= rd;
      border_o_r <= border_nxt;
      mic_o_r    <= mic_nxt;
      beeper_o_r <= beeper_nxt;
      ev_r       <= ev;
      ecyc_r     <= ecyc;
      elev_r     <= elev;
      edrop_r    <= edrop;
      eidx_r     <= eidx;
      start_o_r  <= start_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = rd_r;
  assign out_border_color = border_o_r;
  assign out_mic_out      = mic_o_r;
  assign out_beeper_out   = beeper_o_r;
  assign out_edge_valid   = ev_r;
  assign out_edge_cycle   = ecyc_r;
  assign out_edge_level   = elev_r;
  assign out_edge_dropped = edrop_r;
  assign out_edge_index   = eidx_r;
  assign out_start_level  = start_o_r;

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
      count_r <= CW'(MAX_EDGES))
    else $error("edge count beyond limit");
  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
      q_pop && (q_head.op == OP_FRAME) |=> count_r == '0)
    else $error("frame start did not clear edge count");
  a_edge_level: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && ev_r |-> (beeper_o_r == elev_r) && !edrop_r)
    else $error("logged edge disagrees with beeper level");

endmodule

/* sv/ula_port_keyboard_beeper_unit.sv */
// Top level of the even-port keyboard, border, mic and beeper block.
//
//   channel  direction  handshake         payload
//   in_      request    in_valid/in_stall   kind, key, port address, write data, cycle, ear
//   out_     result     out_valid/out_stall read data, border, mic, beeper, edge record
//   cfg_     write      cfg_valid/cfg_ready frame_cycles (18 bits)
//
// One request per cycle sustained while the queue is not full; an accepted request is written
// into the queue, then executed from the queue head into the output register.
// The back end applies one request per cycle from the queue head to the state while the output register is not stalled.
// Reset is synchronous and active low; no clearing pass.
// A result stall holds the output register; the queue keeps taking requests until full.
module ula_port_keyboard_beeper_unit #(
  parameter int MAX_EDGES   = 1024,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_key_row,
  input  logic [3:0]  in_key_bit,
  input  logic        in_key_pressed,
  input  logic [7:0]  in_port_addr,
  input  logic [7:0]  in_row_select,
  input  logic [7:0]  in_write_value,
  input  logic [17:0] in_cycle,
  input  logic        in_ear_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [2:0]  out_border_color,
  output logic        out_mic_out,
  output logic        out_beeper_out,
  output logic        out_edge_valid,
  output logic [17:0] out_edge_cycle,
  output logic        out_edge_level,
  output logic        out_edge_dropped,
  output logic [15:0] out_edge_index,
  output logic        out_start_level,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [17:0] cfg_data
);
  import ulakb_pkg::*;

  ulakb_req_t push_req;
  ulakb_req_t head_req;
  logic       q_push, q_pop, q_full, q_not_empty;

  ulakb_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_key_row     (in_key_row),
    .in_key_bit     (in_key_bit),
    .in_key_pressed (in_key_pressed),
    .in_port_addr   (in_port_addr),
    .in_row_select  (in_row_select),
    .in_write_value (in_write_value),
    .in_cycle       (in_cycle),
    .in_ear_level   (in_ear_level),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_req          (push_req)
  );

  ulakb_queue #(
    .WIDTH ($bits(ulakb_req_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_req),
    .pop       (q_pop),
    .head_data (head_req),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  ulakb_back #(
    .MAX_EDGES (MAX_EDGES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .q_not_empty      (q_not_empty),
    .q_head           (head_req),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_border_color (out_border_color),
    .out_mic_out      (out_mic_out),
    .out_beeper_out   (out_beeper_out),
    .out_edge_valid   (out_edge_valid),
    .out_edge_cycle   (out_edge_cycle),
    .out_edge_level   (out_edge_level),
    .out_edge_dropped (out_edge_dropped),
    .out_edge_index   (out_edge_index),
    .out_start_level  (out_start_level)
  );

endmodule
